// ===== hdl/lgs_pkg.sv =====
// Shared constants, types and codes for the Life generation stencil.
package lgs_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;

  localparam int COL_W = $clog2(MAX_COLS);  // column index
  localparam int CW    = COL_W + 1;         // column count, holds MAX_COLS + 1
  localparam int ROW_W = $clog2(MAX_ROWS);  // row index
  localparam int RW    = ROW_W + 1;         // row count, holds MAX_ROWS + 1

  localparam int NUM_COLS_W  = 11;
  localparam int NUM_ROWS_W  = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int RES_ROW_W   = 12;
  localparam int RES_COL_W   = 10;
  localparam int COUNT_W     = 4;

  localparam int COLS_RESET = 500;
  localparam int ROWS_RESET = 500;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS = 2'd1;

  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // One line store entry: the cell two rows up and the cell one row up.
  typedef struct packed {
    logic upper;
    logic middle;
  } line_t;

  // Stencil column, bit 0 top, bit 2 bottom.
  typedef logic [2:0] column_t;

  // Stream position of the item at the input.
  typedef struct packed {
    logic             drain;
    logic [COL_W-1:0] col;
    logic [RW-1:0]    row;
  } pos_t;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/lgs_line_buffer.sv =====
// Two-row line store: one write and one registered read per cycle, with write bypass.
module lgs_line_buffer (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [lgs_pkg::COL_W-1:0] wr_addr,
  input  lgs_pkg::line_t       wr_data,
  input  logic [lgs_pkg::COL_W-1:0] rd_addr,
  output lgs_pkg::line_t       rd_data
);
  import lgs_pkg::*;

  line_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // forward the entry being written when the next read hits it (one-column grid)
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lgs_column_cell.sv =====
// One stencil column cell: holds three vertical cells and takes its neighbor's column.
module lgs_column_cell (
  input  logic                clk,
  input  logic                rst,
  input  lgs_pkg::cell_ctrl_t ctrl,
  input  lgs_pkg::column_t    d,
  output lgs_pkg::column_t    q
);
  import lgs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.step) begin
      q <= d;
    end
  end

endmodule

// ===== hdl/lgs_sequencer.sv =====
// Raster position counters and drain tracking for the input stream.
module lgs_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      cfg_restart,
  input  logic [lgs_pkg::CW-1:0]    cols,
  input  logic [lgs_pkg::RW-1:0]    rows,
  output lgs_pkg::pos_t             pos,
  output logic [lgs_pkg::COL_W-1:0] col_next,
  output logic                      window_clear
);
  import lgs_pkg::*;

  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] in_col, in_col_next;
  logic [CW-1:0]    drain_left, drain_left_next;
  logic             drain;
  logic [CW-1:0]    col_inc;
  logic             col_wrap;
  logic [RW-1:0]    row_inc;
  logic             drain_done;

  always_comb begin
    drain      = (drain_left != '0);
    col_inc    = CW'(in_col) + CW'(1);
    col_wrap   = (col_inc >= cols);
    row_inc    = RW'(in_row) + RW'(1);
    drain_done = accept && drain && (drain_left == CW'(1));

    pos.drain = drain;
    pos.col   = in_col;
    // the last drain position sits one row below the other drain positions
    pos.row   = drain ? (rows + RW'(drain_left == CW'(1))) : RW'(in_row);

    window_clear = cfg_restart || drain_done;

    in_row_next     = in_row;
    in_col_next     = in_col;
    drain_left_next = drain_left;
    if (window_clear) begin
      in_row_next     = '0;
      in_col_next     = '0;
      drain_left_next = '0;
    end else if (accept) begin
      in_col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
      if (drain) begin
        drain_left_next = drain_left - CW'(1);
      end else if (col_wrap) begin
        if (row_inc >= rows) begin
          in_row_next     = '0;
          drain_left_next = cols + CW'(1);
        end else begin
          in_row_next = row_inc[ROW_W-1:0];
        end
      end
    end
    col_next = in_col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= '0;
      in_col     <= '0;
      drain_left <= '0;
    end else begin
      in_row     <= in_row_next;
      in_col     <= in_col_next;
      drain_left <= drain_left_next;
    end
  end

endmodule

// ===== hdl/life_generation_stencil.sv =====
// Top level: one Life generation (B3/S23) over a raster stream of one-bit cells.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   operation, cell_req
//  out      source     out_valid/out_stall next_state, neighbor_count, result_row,
//                                          result_col, is_last
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data (ready always high)
//
// One item per clock while in_stall is low. The line store read for the next column
// is issued in the cycle before, so an item passes the stencil in the cycle it is
// accepted and its result, if any, sits in the output queue on the next cycle.
// A two-entry output queue holds results; in_stall rises only when both are full.
// Reset clears counters, window and queue; the line stores are not cleared.
module life_generation_stencil (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic                              cell_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              next_state,
  output logic [lgs_pkg::COUNT_W-1:0]       neighbor_count,
  output logic [lgs_pkg::RES_ROW_W-1:0]     result_row,
  output logic [lgs_pkg::RES_COL_W-1:0]     result_col,
  output logic                              is_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lgs_pkg::*;

  typedef struct packed {
    logic                 next_state;
    logic [COUNT_W-1:0]   neighbor_count;
    logic [RES_ROW_W-1:0] result_row;
    logic [RES_COL_W-1:0] result_col;
    logic                 is_last;
  } result_t;

  logic [CW-1:0] cols;
  logic [RW-1:0] rows;
  logic [NUM_COLS_W-1:0] cols_raw;
  logic [NUM_ROWS_W-1:0] rows_raw;
  logic          cfg_wr;
  logic          cfg_restart;

  logic          accept;
  pos_t          pos;
  logic [COL_W-1:0] col_next;
  logic          window_clear;
  line_t         line_rd, line_wr;
  logic          v, up, mid;
  column_t       newcol, w1, w2, el, em, er;
  cell_ctrl_t    ctrl_w1, ctrl_w2;
  logic          first_col;
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic          produce;
  logic [COUNT_W-1:0] count;
  logic          center;
  result_t       res_new;

  result_t       slot0, slot1;
  logic [1:0]    fill;
  logic          push, pop;

  function automatic logic [COUNT_W-1:0] bits3(input column_t c);
    bits3 = COUNT_W'(c[0]) + COUNT_W'(c[1]) + COUNT_W'(c[2]);
  endfunction

  // configuration: store clamped values
  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_wr && ((cfg_index == CFG_NUM_COLS) || (cfg_index == CFG_NUM_ROWS));
  assign cols_raw    = cfg_data[NUM_COLS_W-1:0];
  assign rows_raw    = cfg_data[NUM_ROWS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= CW'(COLS_RESET);
      rows <= RW'(ROWS_RESET);
    end else if (cfg_wr) begin
      if (cfg_index == CFG_NUM_COLS) begin
        if (cols_raw == '0) begin
          cols <= CW'(1);
        end else if (cols_raw > MAX_COLS) begin
          cols <= CW'(MAX_COLS);
        end else begin
          cols <= CW'(cols_raw);
        end
      end else if (cfg_index == CFG_NUM_ROWS) begin
        if (rows_raw == '0) begin
          rows <= RW'(1);
        end else if (rows_raw > MAX_ROWS) begin
          rows <= RW'(MAX_ROWS);
        end else begin
          rows <= RW'(rows_raw);
        end
      end
    end
  end

  assign accept = in_valid && !in_stall;

  lgs_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cfg_restart (cfg_restart),
    .cols        (cols),
    .rows        (rows),
    .pos         (pos),
    .col_next    (col_next),
    .window_clear(window_clear)
  );

  lgs_line_buffer u_lines (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(pos.col),
    .wr_data(line_wr),
    .rd_addr(col_next),
    .rd_data(line_rd)
  );

  always_comb begin
    v   = !pos.drain && (operation == OP_CELL) && cell_req;
    // rows above the grid read as dead
    up  = (pos.row >= RW'(2)) ? line_rd.upper  : 1'b0;
    mid = (pos.row >= RW'(1)) ? line_rd.middle : 1'b0;
    newcol = {v, mid, up};
    line_wr.upper  = mid;
    line_wr.middle = v;
    first_col = (pos.col == '0);
  end

  // window: newcol -> w2 -> w1; a new row starts with w1 empty
  always_comb begin
    ctrl_w2.step  = accept;
    ctrl_w2.clear = window_clear;
    ctrl_w1.step  = accept;
    ctrl_w1.clear = window_clear || (accept && first_col);
  end

  lgs_column_cell u_w2 (.clk(clk), .rst(rst), .ctrl(ctrl_w2), .d(newcol), .q(w2));
  lgs_column_cell u_w1 (.clk(clk), .rst(rst), .ctrl(ctrl_w1), .d(w2),     .q(w1));

  always_comb begin
    el = w1;
    em = w2;
    er = first_col ? column_t'(0) : newcol;
    if (first_col) begin
      produce = (pos.row >= RW'(2));
      crow    = pos.row - RW'(2);
      ccol    = cols - CW'(1);
    end else begin
      produce = (pos.row >= RW'(1));
      crow    = pos.row - RW'(1);
      ccol    = CW'(pos.col) - CW'(1);
    end
    produce = produce && (crow < rows);
    center  = em[1];
    count   = bits3(el) + COUNT_W'(em[0]) + COUNT_W'(em[2]) + bits3(er);
    res_new.next_state     = (count == COUNT_W'(3)) || (center && (count == COUNT_W'(2)));
    res_new.neighbor_count = count;
    res_new.result_row     = RES_ROW_W'(crow);
    res_new.result_col     = RES_COL_W'(ccol);
    res_new.is_last        = (crow == rows - RW'(1)) && (ccol == cols - CW'(1));
  end

  // two-entry output queue: slot0 faces the output, slot1 is the skid
  assign push     = accept && produce;
  assign pop      = out_valid && !out_stall;
  assign out_valid = (fill != 2'd0);
  assign in_stall  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (((fill == 2'd0) && push) || ((fill == 2'd1) && pop && push)) begin
      slot0 <= res_new;
    end else if ((fill == 2'd2) && pop) begin
      slot0 <= slot1;
    end
    if ((fill == 2'd1) && push && !pop) begin
      slot1 <= res_new;
    end
  end

  assign next_state     = slot0.next_state;
  assign neighbor_count = slot0.neighbor_count;
  assign result_row     = slot0.result_row;
  assign result_col     = slot0.result_col;
  assign is_last        = slot0.is_last;

endmodule

// ===== hdl/lgs_checker.sv =====
// Port-level checks for the Life generation stencil, bound to the top level.
module lgs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            next_state,
  input logic [lgs_pkg::COUNT_W-1:0]     neighbor_count,
  input logic [lgs_pkg::RES_ROW_W-1:0]   result_row,
  input logic [lgs_pkg::RES_COL_W-1:0]   result_col
);
  import lgs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_row) && $stable(result_col))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> neighbor_count <= COUNT_W'(8))
    else $error("neighbor count above eight");

  a_alive_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid && next_state |-> (neighbor_count == COUNT_W'(2)) || (neighbor_count == COUNT_W'(3)))
    else $error("live cell with wrong neighbor count");

  a_birth_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid && (neighbor_count == COUNT_W'(3)) |-> next_state)
    else $error("three neighbors did not give a live cell");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);
